/* hdl/drrq_pkg.sv */
// Package for the deadline release ring queue.
// Holds the field widths, operation and status codes, and the sequencer state type.
// No dependencies.
package drrq_pkg;

   localparam int VIEW_W = 8;
   localparam int TIME_W = 32;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

/* hdl/drrq_if.sv */
// Valid/ready channel interfaces for the deadline release ring queue.
// Depends on drrq_pkg for the field widths.
interface drrq_req_if
   import drrq_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [VIEW_W-1:0] view_id;
   logic [TIME_W-1:0] time_value;

   modport source (output valid, output op, output view_id, output time_value, input ready);
   modport sink   (input valid, input op, input view_id, input time_value, output ready);
endinterface

interface drrq_rsp_if
   import drrq_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [VIEW_W-1:0] released_view;
   logic              released;
   logic              status;
   logic              last;

   modport source (output valid, output released_view, output released, output status,
                   output last, input ready);
   modport sink   (input valid, input released_view, input released, input status,
                   input last, output ready);
endinterface

/* hdl/deadline_release_ring_queue.sv */
// Top level of the deadline release ring queue: entry memory, scan sequencer, result register.
// Depends on drrq_pkg and the channel interfaces in drrq_if.sv.
//
// The block keeps a ring of up to QUEUE_DEPTH pending (view id, due tick) entries in a
// one-write, one-read memory with registered read data. An enqueue request appends an
// entry at the tail, or reports a full queue, and gives exactly one response: it is
// accepted, then the response is handed to the output register. A release request
// carries the current tick and walks every stored entry once, from the head, through a
// single shared unsigned 32-bit compare: one entry is read per cycle unless the scan is
// stalled, and the entry read in the previous cycle is compared. Entries whose due
// tick is at or below the current tick are released as responses in ring order; the
// others are written back behind the new head, so they keep their order. Each released
// view is held in a pending register until the next due entry or the end of the pass,
// so the block knows which one is the final response and flags it with last; when
// nothing is due, one empty response with last set is given. A stalled response
// channel pauses the scan only when a second due entry is found while the output
// register is still occupied. One request is worked on at a time: req_port.ready is
// high only while the sequencer is idle. The memory needs no clearing after reset,
// since only stored entries are ever read.
module deadline_release_ring_queue
   import drrq_pkg::*;
   #(
      parameter int QUEUE_DEPTH = 16
   )
   (
      input  logic           clock,
      input  logic           reset,
      drrq_req_if.sink       req_port,
      drrq_rsp_if.source     rsp_port
   );

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Entry memory: written at one address and read at one address per cycle.
   logic [VIEW_W-1:0] mem_view [QUEUE_DEPTH];
   logic [TIME_W-1:0] mem_due  [QUEUE_DEPTH];
   logic [VIEW_W-1:0] rd_view_ff;
   logic [TIME_W-1:0] rd_due_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [VIEW_W-1:0] mem_wview;
   logic [TIME_W-1:0] mem_wdue;
   logic              mem_re;

   // Sequencer and queue state.
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic              rdv_ff, rdv_in;

   // One pending response, held until the block knows whether it is the final one.
   logic              hold_valid_ff, hold_valid_in;
   logic [VIEW_W-1:0] hold_view_ff, hold_view_in;
   logic              hold_rel_ff, hold_rel_in;
   logic              hold_status_ff, hold_status_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VIEW_W-1:0] rsp_view_ff, rsp_view_in;
   logic              rsp_rel_ff, rsp_rel_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              due;
   logic              stall;
   logic              full;
   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail_idx;
   logic [IDX_W-1:0]  rd_ptr_next;
   logic [IDX_W-1:0]  wr_ptr_next;

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign due      = (rd_due_ff <= tick_ff);
   assign stall    = rdv_ff && due && hold_valid_ff && !out_free;
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));

   // The tail slot is head plus count, which stays below twice the depth.
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

   assign rd_ptr_next = (rd_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_ptr_next = (wr_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_view[mem_waddr] <= mem_wview;
         mem_due[mem_waddr]  <= mem_wdue;
      end
      if (mem_re) begin
         rd_view_ff <= mem_view[rd_ptr_ff];
         rd_due_ff  <= mem_due[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rdv_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rdv_ff        <= rdv_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff        <= pass_in;
      iss_ff         <= iss_in;
      kept_ff        <= kept_in;
      rd_ptr_ff      <= rd_ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      tick_ff        <= tick_in;
      hold_view_ff   <= hold_view_in;
      hold_rel_ff    <= hold_rel_in;
      hold_status_ff <= hold_status_in;
      rsp_view_ff    <= rsp_view_in;
      rsp_rel_ff     <= rsp_rel_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      pass_in        = pass_ff;
      iss_in         = iss_ff;
      kept_in        = kept_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      tick_in        = tick_ff;
      rdv_in         = rdv_ff;
      hold_valid_in  = hold_valid_ff;
      hold_view_in   = hold_view_ff;
      hold_rel_in    = hold_rel_ff;
      hold_status_in = hold_status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_view_in   = rsp_view_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      mem_we    = 1'b0;
      mem_waddr = wr_ptr_ff;
      mem_wview = rd_view_ff;
      mem_wdue  = rd_due_ff;
      mem_re    = 1'b0;

      req_port.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               if (req_port.op == OP_ENQUEUE) begin
                  hold_valid_in  = 1'b1;
                  hold_view_in   = '0;
                  hold_rel_in    = 1'b0;
                  hold_status_in = full ? STATUS_FULL : STATUS_OK;
                  if (!full) begin
                     mem_we    = 1'b1;
                     mem_waddr = tail_idx;
                     mem_wview = req_port.view_id;
                     mem_wdue  = req_port.time_value;
                     count_in  = count_ff + 1'b1;
                  end
                  state_in = ST_DRAIN;
               end else begin
                  // The head moves past every visited entry; kept entries land behind it.
                  tick_in       = req_port.time_value;
                  pass_in       = count_ff;
                  iss_in        = '0;
                  kept_in       = '0;
                  rd_ptr_in     = head_ff;
                  wr_ptr_in     = tail_idx;
                  head_in       = tail_idx;
                  hold_valid_in = 1'b0;
                  rdv_in        = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               if (rdv_ff) begin
                  if (due) begin
                     if (hold_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_view_in   = hold_view_ff;
                        rsp_rel_in    = hold_rel_ff;
                        rsp_status_in = hold_status_ff;
                        rsp_last_in   = 1'b0;
                     end
                     hold_valid_in  = 1'b1;
                     hold_view_in   = rd_view_ff;
                     hold_rel_in    = 1'b1;
                     hold_status_in = STATUS_OK;
                  end else begin
                     mem_we    = 1'b1;
                     wr_ptr_in = wr_ptr_next;
                     kept_in   = kept_ff + 1'b1;
                  end
               end
               if (iss_ff != pass_ff) begin
                  mem_re    = 1'b1;
                  rd_ptr_in = rd_ptr_next;
                  iss_in    = iss_ff + 1'b1;
                  rdv_in    = 1'b1;
               end else begin
                  rdv_in = 1'b0;
               end
               if ((iss_ff == pass_ff) && !rdv_ff) begin
                  count_in = kept_ff;
                  if (!hold_valid_ff) begin
                     hold_valid_in  = 1'b1;
                     hold_view_in   = '0;
                     hold_rel_in    = 1'b0;
                     hold_status_in = STATUS_OK;
                  end
                  state_in = ST_DRAIN;
               end
            end
         end

         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_view_in   = hold_view_ff;
               rsp_rel_in    = hold_rel_ff;
               rsp_status_in = hold_status_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.released_view = rsp_view_ff;
   assign rsp_port.released      = rsp_rel_ff;
   assign rsp_port.status        = rsp_status_ff;
   assign rsp_port.last          = rsp_last_ff;

endmodule
